@@ rtl/core/npt_pkg.sv @@
// Package for the neighbor presence tracker: sizes, command codes,
// store entry and request types, slot reduction helper.
// No dependencies.
package npt_pkg;

    localparam int NODE_COUNT   = 256;
    localparam int WINDOW_SLOTS = 8;

    localparam int ADDR_W = $clog2(NODE_COUNT);
    localparam int NBR_W  = $clog2(NODE_COUNT + 1);
    localparam int SLOT_W = $clog2(WINDOW_SLOTS);
    localparam int PCNT_W = 4;
    localparam int ID_W   = 8;
    localparam int RND_W  = 3;
    localparam int SEC_W  = 8;

    localparam logic [SEC_W-1:0]  SEC_RESET     = 8'd10;
    localparam logic [PCNT_W-1:0] PRESENCE_LOAD = PCNT_W'(WINDOW_SLOTS);
    localparam logic [ID_W:0]     ID_LIMIT      = (ID_W + 1)'(NODE_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(NODE_COUNT - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT     = SLOT_W'(WINDOW_SLOTS - 1);
    localparam logic [SLOT_W-1:0] SKIP_RESET    = SLOT_W'(1);

    localparam logic CMD_BEACON = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef struct packed {
        logic              seen;
        logic [PCNT_W-1:0] cnt;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_wr_req;

    // random slot reduced into the slot range (up to four conditional subtractions)
    function automatic logic [SLOT_W-1:0] slot_mod(input logic [RND_W-1:0] rnd);
        logic [4:0] v;
        v = 5'(rnd);
        for (int k = 0; k < 4; k++) begin
            if (v >= 5'(WINDOW_SLOTS)) begin
                v = v - 5'(WINDOW_SLOTS);
            end
        end
        return SLOT_W'(v);
    endfunction

endpackage

@@ rtl/core/npt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module npt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/npt_store.sv @@
// Per-node presence counter and seen bit store: RAM plus per-entry valid
// flops cleared at reset, so unwritten entries read as zero.
// Depends on npt_pkg and npt_ram.
module npt_store (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  npt_pkg::t_rd_req i_rd,
    input  npt_pkg::t_wr_req i_wr,
    output npt_pkg::t_entry  o_entry
);

    logic [npt_pkg::NODE_COUNT-1:0] r_valid;
    logic                           r_rd_valid;
    logic [$bits(npt_pkg::t_entry)-1:0] ram_rdata;

    npt_ram #(
        .WIDTH ($bits(npt_pkg::t_entry)),
        .DEPTH (npt_pkg::NODE_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd.en),
        .i_raddr (i_rd.addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_valid <= r_valid[i_rd.addr];
            end
        end
    end

    assign o_entry = r_rd_valid ? npt_pkg::t_entry'(ram_rdata) : '0;

endmodule

@@ rtl/core/neighbor_presence_tracker.sv @@
// Top level of the neighbor presence tracker: command sequencer, window
// timer, slot logic and the shared counter scan over the presence store.
// Depends on npt_pkg and npt_store.
//
//  channel  | handshake            | beat contents
//  ---------+----------------------+-------------------------------------------
//  command  | start, busy          | i_cmd, i_badge_id, i_random_slot
//  result   | o_strobe (one cycle) | o_newly_met, o_window_end, o_nbr_total,
//           |                      | o_beacon_request, o_radio_restart
//  config   | i_cfg_valid, o_cfg_ready | i_cfg_wdata (window length in seconds)
//
// Beacon: busy during the store read (ST_BCN); result strobe as busy drops.
// Tick without window end: result strobe the cycle after accept, not busy.
// Window end: busy while the scan walks the store, one store entry per cycle
// through the decrement/count unit; the result strobe is registered from the
// last store entry of the scan.
// Reset clears the store valid bits at once; results cannot be stalled.
module neighbor_presence_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cmd,
    input  logic [npt_pkg::ID_W-1:0]      i_badge_id,
    input  logic [npt_pkg::RND_W-1:0]     i_random_slot,
    output logic                          o_strobe,
    output logic                          o_newly_met,
    output logic                          o_window_end,
    output logic [npt_pkg::NBR_W-1:0]     o_nbr_total,
    output logic                          o_beacon_request,
    output logic                          o_radio_restart,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [npt_pkg::SEC_W-1:0]     i_cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BCN  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]                      r_state, n_state;
    logic [npt_pkg::SEC_W-1:0]       r_secs, n_secs;
    logic [npt_pkg::SEC_W-1:0]       r_win_len;
    logic [npt_pkg::SLOT_W-1:0]      r_slot, n_slot;
    logic [npt_pkg::SLOT_W-1:0]      r_skip, n_skip;
    logic [npt_pkg::NBR_W-1:0]       r_last_count, n_last_count;
    logic [npt_pkg::NBR_W-1:0]       r_count, n_count;
    logic [npt_pkg::ADDR_W-1:0]      r_daddr, n_daddr;
    logic [npt_pkg::ADDR_W-1:0]      r_bcn_addr, n_bcn_addr;
    logic [npt_pkg::RND_W-1:0]       r_rnd, n_rnd;
    logic                            r_breq, n_breq;
    logic                            r_strobe, n_strobe;
    logic                            r_met, n_met;
    logic                            r_wend, n_wend;
    logic                            r_breq_o, n_breq_o;
    logic                            r_rrst, n_rrst;

    npt_pkg::t_rd_req                rd;
    npt_pkg::t_wr_req                wr;
    npt_pkg::t_entry                 entry;

    logic [npt_pkg::SEC_W-1:0]       secs_dec;
    logic                            live;
    logic [npt_pkg::NBR_W-1:0]       cnt_sum;

    npt_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd),
        .i_wr    (wr),
        .o_entry (entry)
    );

    assign secs_dec = r_secs - 1'b1;
    assign live     = (entry.cnt != '0);
    assign cnt_sum  = r_count + npt_pkg::NBR_W'(live);

    always_comb begin
        n_state      = r_state;
        n_secs       = r_secs;
        n_slot       = r_slot;
        n_skip       = r_skip;
        n_last_count = r_last_count;
        n_count      = r_count;
        n_daddr      = r_daddr;
        n_bcn_addr   = r_bcn_addr;
        n_rnd        = r_rnd;
        n_breq       = r_breq;
        n_strobe     = 1'b0;
        n_met        = 1'b0;
        n_wend       = 1'b0;
        n_breq_o     = 1'b0;
        n_rrst       = 1'b0;
        rd           = '0;
        wr           = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_cmd == npt_pkg::CMD_BEACON) begin
                        if ({1'b0, i_badge_id} < npt_pkg::ID_LIMIT) begin
                            rd.en      = 1'b1;
                            rd.addr    = npt_pkg::ADDR_W'(i_badge_id);
                            n_bcn_addr = npt_pkg::ADDR_W'(i_badge_id);
                            n_state    = ST_BCN;
                        end else begin
                            n_strobe = 1'b1;
                        end
                    end else begin
                        n_secs = secs_dec;
                        if (secs_dec == '0) begin
                            n_secs  = r_win_len;
                            n_breq  = (r_skip != r_slot);
                            n_rnd   = i_random_slot;
                            n_count = '0;
                            n_daddr = '0;
                            rd.en   = 1'b1;
                            rd.addr = '0;
                            n_state = ST_SCAN;
                        end else begin
                            n_strobe = 1'b1;
                        end
                    end
                end
            end
            ST_BCN: begin
                wr.en        = 1'b1;
                wr.addr      = r_bcn_addr;
                wr.data.seen = 1'b1;
                wr.data.cnt  = npt_pkg::PRESENCE_LOAD;
                n_met        = !entry.seen;
                n_strobe     = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_SCAN: begin
                wr.en        = live;
                wr.addr      = r_daddr;
                wr.data.seen = entry.seen;
                wr.data.cnt  = entry.cnt - 1'b1;
                if (r_daddr == npt_pkg::LAST_ADDR) begin
                    n_last_count = cnt_sum;
                    n_wend       = 1'b1;
                    n_breq_o     = r_breq;
                    n_strobe     = 1'b1;
                    n_state      = ST_IDLE;
                    if (r_slot == npt_pkg::LAST_SLOT) begin
                        n_slot = '0;
                        n_skip = npt_pkg::slot_mod(r_rnd);
                        n_rrst = (cnt_sum == '0);
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end else begin
                    rd.en   = 1'b1;
                    rd.addr = r_daddr + 1'b1;
                    n_daddr = r_daddr + 1'b1;
                    n_count = cnt_sum;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_secs       <= npt_pkg::SEC_RESET;
            r_win_len    <= npt_pkg::SEC_RESET;
            r_slot       <= '0;
            r_skip       <= npt_pkg::SKIP_RESET;
            r_last_count <= '0;
            r_strobe     <= 1'b0;
            r_met        <= 1'b0;
            r_wend       <= 1'b0;
            r_breq_o     <= 1'b0;
            r_rrst       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_secs       <= n_secs;
            r_slot       <= n_slot;
            r_skip       <= n_skip;
            r_last_count <= n_last_count;
            r_strobe     <= n_strobe;
            r_met        <= n_met;
            r_wend       <= n_wend;
            r_breq_o     <= n_breq_o;
            r_rrst       <= n_rrst;
            if (i_cfg_valid) begin
                r_win_len <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_count    <= n_count;
        r_daddr    <= n_daddr;
        r_bcn_addr <= n_bcn_addr;
        r_rnd      <= n_rnd;
        r_breq     <= n_breq;
    end

    assign busy             = (r_state != ST_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_strobe         = r_strobe;
    assign o_newly_met      = r_met;
    assign o_window_end     = r_wend;
    assign o_nbr_total      = r_last_count;
    assign o_beacon_request = r_breq_o;
    assign o_radio_restart  = r_rrst;

    a_scan_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_daddr == npt_pkg::LAST_ADDR)
        |=> (o_strobe && o_window_end && !busy))
        else $error("scan end without window-end result");

    a_restart_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_radio_restart) |-> (o_window_end && o_nbr_total == '0))
        else $error("radio restart with neighbors or outside window end");

    a_met_not_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_newly_met) |-> !o_window_end)
        else $error("newly_met on a window-end beat");

    a_breq_wend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_beacon_request) |-> o_window_end)
        else $error("beacon request outside window end");

    a_bcn_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BCN) |=> (o_strobe && !busy))
        else $error("beacon lookup did not complete");

endmodule
